FILE: rtl/core/lux_from_light_channels_defines.svh
// Assertion macros used by the checker file of the lux block.
`ifndef LUX_FROM_LIGHT_CHANNELS_DEFINES_SVH
`define LUX_FROM_LIGHT_CHANNELS_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent, outside reset.
`define LFL_ASSERT_IMM(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent, outside reset.
`define LFL_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent, checked during reset too.
`define LFL_ASSERT_ALL(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/lfl_pkg.sv
// Shared types, constants, coefficient tables and helpers of the lux block.
package lfl_pkg;

    // Raw reading width and fixed-point fractions.
    localparam int CHANNEL_WIDTH = 16;
    localparam int FRAC_CH       = 10;
    localparam int FRAC_RATIO    = 9;
    localparam int FRAC_LUX      = 14;
    localparam int SEGMENTS      = 7;
    localparam int GAIN_SHIFT    = 4;

    // The largest scale is 0x7517 shifted up by the gain shift, which needs 19 bits.
    localparam int SCALE_W  = 15 + GAIN_SHIFT;
    localparam int CH_W     = CHANNEL_WIDTH + SCALE_W - FRAC_CH;
    localparam int QUO_W    = FRAC_RATIO + 2;
    localparam int REM_W    = CH_W + QUO_W;
    localparam int COEF_W   = 10;
    localparam int PROD_W   = CH_W + COEF_W;
    localparam int LUX_W    = 16;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_HIGH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_INTEG_TIME = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_PACKAGE_CS = CFG_IDX_W'(2);

    // Integration time codes.
    typedef enum logic [1:0] {
        ITIME_13MS   = 2'd0,
        ITIME_101MS  = 2'd1,
        ITIME_402MS  = 2'd2,
        ITIME_MANUAL = 2'd3
    } t_itime;

    localparam logic [SCALE_W-1:0] SCALE_13MS  = SCALE_W'(32'h7517);
    localparam logic [SCALE_W-1:0] SCALE_101MS = SCALE_W'(32'h0fe7);
    localparam logic [SCALE_W-1:0] SCALE_UNIT  = SCALE_W'(1) << FRAC_CH;

    // Segment tables, row 0 for the T/FN/CL package and row 1 for the CS package.
    localparam logic [COEF_W-1:0] SEG_BREAK [2][SEGMENTS] = '{
        '{10'h040, 10'h080, 10'h0c0, 10'h100, 10'h138, 10'h19a, 10'h29a},
        '{10'h043, 10'h085, 10'h0c8, 10'h10a, 10'h14d, 10'h19a, 10'h29a}
    };
    localparam logic [COEF_W-1:0] SEG_OFFSET [2][SEGMENTS] = '{
        '{10'h1f2, 10'h214, 10'h23f, 10'h270, 10'h16f, 10'h0d2, 10'h018},
        '{10'h204, 10'h228, 10'h253, 10'h282, 10'h177, 10'h101, 10'h037}
    };
    localparam logic [COEF_W-1:0] SEG_SLOPE [2][SEGMENTS] = '{
        '{10'h1be, 10'h2d1, 10'h37b, 10'h3fe, 10'h1fc, 10'h0fb, 10'h012},
        '{10'h1ad, 10'h2c1, 10'h363, 10'h3df, 10'h1dd, 10'h127, 10'h02b}
    };

    typedef struct packed {
        logic [COEF_W-1:0] offset;
        logic [COEF_W-1:0] slope;
    } t_coef;

    // Result of the ratio divider as it leaves the divider pipeline.
    typedef struct packed {
        logic             valid;
        logic             over;
        logic [QUO_W-1:0] quo;
    } t_div_res;

    // Channel scale for the integration time and gain settings.
    function automatic logic [SCALE_W-1:0] scale_of(t_itime itime, logic gain_high);
        logic [SCALE_W-1:0] s;
        case (itime)
            ITIME_13MS:  s = SCALE_13MS;
            ITIME_101MS: s = SCALE_101MS;
            default:     s = SCALE_UNIT;
        endcase
        if (!gain_high) begin
            s = s << GAIN_SHIFT;
        end
        return s;
    endfunction

    // Pick the first segment whose break is not below the ratio; past the last
    // break, or when the ratio overflowed, offset and slope are both zero.
    function automatic t_coef seg_coef(logic pkg_cs, logic [QUO_W-1:0] ratio, logic over);
        t_coef c;
        logic  found;
        c     = '0;
        found = 1'b0;
        if (!over) begin
            for (int i = 0; i < SEGMENTS; i++) begin
                if (!found && ratio <= QUO_W'(SEG_BREAK[pkg_cs][i])) begin
                    c.offset = SEG_OFFSET[pkg_cs][i];
                    c.slope  = SEG_SLOPE[pkg_cs][i];
                    found    = 1'b1;
                end
            end
        end
        return c;
    endfunction

endpackage

FILE: rtl/core/lfl_ratio_div.sv
// Pipelined restoring divider for the infrared to broadband ratio.
module lfl_ratio_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [lfl_pkg::CH_W-1:0]      i_ch0,
    input  logic [lfl_pkg::CH_W-1:0]      i_ch1,
    output lfl_pkg::t_div_res             o_res,
    output logic [lfl_pkg::CH_W-1:0]      o_ch0,
    output logic [lfl_pkg::CH_W-1:0]      o_ch1
);

    localparam int QW = lfl_pkg::QUO_W;

    // Entry 0 is the setup stage; entry j+1 holds the item after quotient step j.
    logic [QW:0]                   r_valid;
    logic                          r_zero [0:QW];
    logic                          r_over [0:QW];
    logic [lfl_pkg::REM_W-1:0]     r_rem  [0:QW];
    logic [QW-1:0]                 r_quo  [0:QW];
    logic [lfl_pkg::CH_W-1:0]      r_ch0  [0:QW];
    logic [lfl_pkg::CH_W-1:0]      r_ch1  [0:QW];

    logic [lfl_pkg::REM_W-1:0]     n_div  [0:QW-1];
    logic [lfl_pkg::REM_W-1:0]     n_rem  [0:QW-1];
    logic                          n_bit  [0:QW-1];

    // One quotient bit per stage, most significant bit first.
    always_comb begin
        for (int j = 0; j < QW; j++) begin
            n_div[j] = lfl_pkg::REM_W'(r_ch0[j]) << (QW - 1 - j);
            n_bit[j] = (r_rem[j] >= n_div[j]);
            n_rem[j] = n_bit[j] ? (r_rem[j] - n_div[j]) : r_rem[j];
        end
    end

    // Valid bits advance with the pipeline enable.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[QW-1:0], i_valid};
        end
    end

    // Payload stages. A quotient of 2048 or more is flagged in the setup stage,
    // which keeps the remainder below the divisor shifted by the quotient width.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ch0[0]  <= i_ch0;
            r_ch1[0]  <= i_ch1;
            r_zero[0] <= (i_ch0 == '0);
            r_over[0] <= (i_ch0 != '0) && ({1'b0, i_ch1} >= {i_ch0, 1'b0});
            r_rem[0]  <= lfl_pkg::REM_W'({i_ch1, {(QW - 1){1'b0}}});
            r_quo[0]  <= '0;
            for (int j = 0; j < QW; j++) begin
                r_ch0[j+1]  <= r_ch0[j];
                r_ch1[j+1]  <= r_ch1[j];
                r_zero[j+1] <= r_zero[j];
                r_over[j+1] <= r_over[j];
                r_rem[j+1]  <= n_rem[j];
                r_quo[j+1]  <= {r_quo[j][QW-2:0], n_bit[j]};
            end
        end
    end

    // A zero broadband value yields a zero quotient, so the ratio rounds to zero.
    assign o_res.valid = r_valid[QW];
    assign o_res.over  = r_over[QW];
    assign o_res.quo   = r_zero[QW] ? '0 : r_quo[QW];
    assign o_ch0       = r_ch0[QW];
    assign o_ch1       = r_ch1[QW];

endmodule

FILE: rtl/core/lux_from_light_channels.sv
// Top level of the two-channel lux calculation pipeline.
//
// Input channel: i_in_valid / o_in_ready with the broadband and infrared counts.
// An item is taken at a clock edge where both are high. Output channel:
// o_out_valid / i_out_ready with the lux value, taken the same way.
// Configuration channel: i_cfg_valid / o_cfg_ready with a register index and
// data; it is always ready. Index 0 is gain_high, 1 the integration time code,
// 2 the package select; other indexes are ignored. Write it only while idle.
// Registered steps after the edge that takes the item: channel scaling,
// divider setup, eleven quotient bits, segment lookup, coefficient multiply,
// final round and saturate. Throughput: one item per cycle while the receiver
// does not stall a waiting result; the divider makes up most of the depth.
// Reset (synchronous, active low) empties the pipeline and loads the register
// defaults: gain 1x, 402 ms integration, T/FN/CL coefficient table.
// When the receiver stalls a waiting result, the whole pipeline holds and
// o_in_ready drops; items inside keep their place and none is lost.
module lux_from_light_channels (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic [lfl_pkg::CHANNEL_WIDTH-1:0]     i_broadband_count,
    input  logic [lfl_pkg::CHANNEL_WIDTH-1:0]     i_infrared_count,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic [lfl_pkg::LUX_W-1:0]             o_lux_value,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [lfl_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [lfl_pkg::CFG_DATA_W-1:0]        i_cfg_data
);

    localparam int RAW_PROD_W = lfl_pkg::CHANNEL_WIDTH + lfl_pkg::SCALE_W;
    localparam int SHIFT_W    = lfl_pkg::PROD_W + 1 - lfl_pkg::FRAC_LUX;

    logic                            r_gain_high;
    lfl_pkg::t_itime                 r_itime;
    logic                            r_package_cs;

    logic                            w_en;
    logic [lfl_pkg::SCALE_W-1:0]     w_scale;
    logic [RAW_PROD_W-1:0]           n_prod0;
    logic [RAW_PROD_W-1:0]           n_prod1;

    logic                            r_a_valid;
    logic [lfl_pkg::CH_W-1:0]        r_a_ch0;
    logic [lfl_pkg::CH_W-1:0]        r_a_ch1;

    lfl_pkg::t_div_res               w_div;
    logic [lfl_pkg::CH_W-1:0]        w_div_ch0;
    logic [lfl_pkg::CH_W-1:0]        w_div_ch1;

    logic [lfl_pkg::QUO_W:0]         n_round_quo;
    logic [lfl_pkg::QUO_W-1:0]       n_ratio;
    lfl_pkg::t_coef                  n_coef;

    logic                            r_l_valid;
    lfl_pkg::t_coef                  r_l_coef;
    logic [lfl_pkg::CH_W-1:0]        r_l_ch0;
    logic [lfl_pkg::CH_W-1:0]        r_l_ch1;

    logic                            r_m_valid;
    logic [lfl_pkg::PROD_W-1:0]      r_m_pos;
    logic [lfl_pkg::PROD_W-1:0]      r_m_neg;

    logic [lfl_pkg::PROD_W-1:0]      n_diff;
    logic [lfl_pkg::PROD_W:0]        n_round;
    logic [SHIFT_W-1:0]              n_shift;
    logic [lfl_pkg::LUX_W-1:0]       n_lux;

    logic                            r_f_valid;
    logic [lfl_pkg::LUX_W-1:0]       r_f_lux;

    // The pipeline moves whenever the output register is empty or being taken.
    assign w_en        = !r_f_valid || i_out_ready;
    assign o_in_ready  = w_en;
    assign o_cfg_ready = 1'b1;

    // Configuration registers keep only their own width.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_high  <= 1'b0;
            r_itime      <= lfl_pkg::ITIME_402MS;
            r_package_cs <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                lfl_pkg::CFG_GAIN_HIGH:  r_gain_high  <= i_cfg_data[0];
                lfl_pkg::CFG_INTEG_TIME: r_itime      <= lfl_pkg::t_itime'(i_cfg_data[1:0]);
                lfl_pkg::CFG_PACKAGE_CS: r_package_cs <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Scale both channels for integration time and gain.
    assign w_scale = lfl_pkg::scale_of(r_itime, r_gain_high);
    assign n_prod0 = RAW_PROD_W'(i_broadband_count) * RAW_PROD_W'(w_scale);
    assign n_prod1 = RAW_PROD_W'(i_infrared_count) * RAW_PROD_W'(w_scale);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_en) begin
            r_a_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_ch0 <= n_prod0[RAW_PROD_W-1:lfl_pkg::FRAC_CH];
            r_a_ch1 <= n_prod1[RAW_PROD_W-1:lfl_pkg::FRAC_CH];
        end
    end

    // Ratio of infrared to broadband in 2^-10 units.
    lfl_ratio_div u_ratio_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_a_valid),
        .i_ch0   (r_a_ch0),
        .i_ch1   (r_a_ch1),
        .o_res   (w_div),
        .o_ch0   (w_div_ch0),
        .o_ch1   (w_div_ch1)
    );

    // Round the ratio to 2^-9 units and look up the segment coefficients.
    assign n_round_quo = {1'b0, w_div.quo} + (lfl_pkg::QUO_W + 1)'(1);
    assign n_ratio     = n_round_quo[lfl_pkg::QUO_W:1];
    assign n_coef      = lfl_pkg::seg_coef(r_package_cs, n_ratio, w_div.over);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_l_valid <= 1'b0;
            r_m_valid <= 1'b0;
            r_f_valid <= 1'b0;
        end else if (w_en) begin
            r_l_valid <= w_div.valid;
            r_m_valid <= r_l_valid;
            r_f_valid <= r_m_valid;
        end
    end

    // Lookup stage and coefficient multiply stage.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_l_coef <= n_coef;
            r_l_ch0  <= w_div_ch0;
            r_l_ch1  <= w_div_ch1;
            r_m_pos  <= lfl_pkg::PROD_W'(r_l_ch0) * lfl_pkg::PROD_W'(r_l_coef.offset);
            r_m_neg  <= lfl_pkg::PROD_W'(r_l_ch1) * lfl_pkg::PROD_W'(r_l_coef.slope);
        end
    end

    // Clamp a negative difference to zero, round, shift down and saturate.
    always_comb begin
        n_diff  = r_m_pos - r_m_neg;
        n_round = {1'b0, n_diff} + ((lfl_pkg::PROD_W + 1)'(1) << (lfl_pkg::FRAC_LUX - 1));
        n_shift = n_round[lfl_pkg::PROD_W:lfl_pkg::FRAC_LUX];
        if (r_m_pos <= r_m_neg) begin
            n_lux = '0;
        end else if (|n_shift[SHIFT_W-1:lfl_pkg::LUX_W]) begin
            n_lux = '1;
        end else begin
            n_lux = n_shift[lfl_pkg::LUX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f_lux <= n_lux;
        end
    end

    assign o_out_valid = r_f_valid;
    assign o_lux_value = r_f_lux;

endmodule

FILE: rtl/core/lfl_checker.sv
// Port-level assertions for the lux block and the bind that attaches them.
`include "lux_from_light_channels_defines.svh"

module lfl_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          o_in_ready,
    input  logic                          o_out_valid,
    input  logic                          i_out_ready,
    input  logic [lfl_pkg::LUX_W-1:0]     o_lux_value,
    input  logic                          o_cfg_ready
);

    // A stalled result stays put with its value.
    `LFL_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_lux_value), "lfl: stalled item changed or vanished")

    // A stall at the output holds the whole pipeline, so no item may enter.
    `LFL_ASSERT_IMM(a_stall_blocks_input, i_clk, i_rst_n, o_out_valid && !i_out_ready, !o_in_ready, "lfl: item accepted while output stalled")

    // With the output register empty both the input and configuration ports are open.
    `LFL_ASSERT_IMM(a_open_when_empty, i_clk, i_rst_n, !o_out_valid, o_in_ready && o_cfg_ready, "lfl: ports not ready with empty output")

    // Reset empties the output register.
    `LFL_ASSERT_ALL(a_reset_empties, i_clk, !i_rst_n, !o_out_valid, "lfl: output valid right after reset")

endmodule

bind lux_from_light_channels lfl_checker u_lfl_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_lux_value (o_lux_value),
    .o_cfg_ready (o_cfg_ready)
);
